// ----- design/load_cell_adc_reader_assert.svh -----
`ifndef LOAD_CELL_ADC_READER_ASSERT_SVH
`define LOAD_CELL_ADC_READER_ASSERT_SVH

// Clocked assertion, off while in reset
`define LCAR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Implication from a sampled condition to a property
`define LCAR_IMPLY(label, cond, prop, msg) \
    `LCAR_ASSERT(label, (cond) |-> (prop), msg)

`endif

// ----- design/lcar_pkg.sv -----
`default_nettype none

package lcar_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int FRACTION_BITS = 8;

    localparam int RAW_W      = 24;
    localparam int WEIGHT_W   = 33;
    localparam int FACTOR_W   = 24;
    localparam int INTERVAL_W = 24;
    localparam int TIMEOUT_W  = 20;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam int DIFF_W     = SAMPLE_BITS + 1;
    localparam int MAG_W      = SAMPLE_BITS + FRACTION_BITS;
    localparam int BIT_CNT_W  = $clog2(SAMPLE_BITS + 1);
    localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 64;
    localparam int M_PAD_W    = M_TDATA_W - (4 + RAW_W + WEIGHT_W);

    localparam logic [FACTOR_W-1:0]   FACTOR_RESET   = FACTOR_W'(1000);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(100000);
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = TIMEOUT_W'(10000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FACTOR   = 2'd0,
        CFG_INTERVAL = 2'd1,
        CFG_TIMEOUT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT      = 3'd1,
        PH_BIT_HIGH  = 3'd2,
        PH_BIT_LOW   = 3'd3,
        PH_GAIN_HIGH = 3'd4,
        PH_GAIN_LOW  = 3'd5
    } phase_t;

    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_DIV  = 1'b1
    } ctl_t;

    typedef struct packed {
        logic             div_req;
        logic             tare_done;
        logic [RAW_W-1:0] raw;
        logic             timed_out;
        logic             read_done;
        logic             clock_pin;
    } tick_res_t;

    typedef struct packed {
        logic [M_PAD_W-1:0]  pad;
        logic [WEIGHT_W-1:0] weight;
        logic                tare_done;
        logic [RAW_W-1:0]    raw;
        logic                timed_out;
        logic                read_done;
        logic                clock_pin;
    } result_t;

endpackage

`default_nettype wire

// ----- design/lcar_div.sv -----
`default_nettype none

module lcar_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lcar_pkg::MAG_W-1:0]    num_mag,
    input  logic                          num_neg,
    input  logic [lcar_pkg::FACTOR_W-1:0] divisor,
    output logic                          done,
    output logic [lcar_pkg::WEIGHT_W-1:0] quotient
);
    import lcar_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [FACTOR_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]     quot_reg, quot_next;
    logic [FACTOR_W-1:0]  dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;

    logic [FACTOR_W:0]    rem_shift;
    logic [FACTOR_W:0]    rem_sub;
    logic                 fits;
    logic [WEIGHT_W-1:0]  q_ext;

    always_comb begin
        rem_shift = {rem_reg, quot_reg[MAG_W-1]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        fits      = rem_shift >= {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(MAG_W);
            rem_next  = '0;
            quot_next = num_mag;
            dvs_next  = divisor;
            neg_next  = num_neg;
        end else if (busy_reg) begin
            rem_next  = fits ? rem_sub[FACTOR_W-1:0] : rem_shift[FACTOR_W-1:0];
            quot_next = {quot_reg[MAG_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    assign q_ext    = WEIGHT_W'(quot_reg);
    assign quotient = neg_reg ? -q_ext : q_ext;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ----- design/lcar_tick.sv -----
`default_nettype none

module lcar_tick (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  logic                            op,
    input  logic                            data_pin,
    input  logic [lcar_pkg::INTERVAL_W-1:0] interval,
    input  logic [lcar_pkg::TIMEOUT_W-1:0]  timeout,
    output lcar_pkg::tick_res_t             res,
    output logic [lcar_pkg::MAG_W-1:0]      num_mag,
    output logic                            num_neg
);
    import lcar_pkg::*;

    phase_t                        phase_reg, phase_next;
    logic [BIT_CNT_W-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [SAMPLE_BITS-1:0]        shift_reg, shift_next;
    logic [INTERVAL_W-1:0]         interval_reg, interval_next;
    logic [TIMEOUT_W-1:0]          wait_reg, wait_next;
    logic signed [SAMPLE_BITS-1:0] offset_reg, offset_next;
    logic                          tare_reg, tare_next;

    logic [INTERVAL_W-1:0]         ivl;
    logic [TIMEOUT_W-1:0]          tmo;
    phase_t                        ph;
    logic                          tare_p;
    logic                          finish;
    logic signed [SAMPLE_BITS-1:0] raw;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [DIFF_W-1:0]      mag;

    always_comb begin
        ivl    = (interval == '0) ? INTERVAL_W'(1) : interval;
        tmo    = (timeout == '0) ? TIMEOUT_W'(1) : timeout;
        tare_p = tare_reg | op;

        interval_next = (interval_reg != '1) ? interval_reg + 1'b1 : interval_reg;
        wait_next     = wait_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        offset_next   = offset_reg;
        tare_next     = tare_p;
        res           = '0;
        finish        = 1'b0;
        raw           = '0;

        ph = phase_reg;
        if (phase_reg == PH_IDLE && interval_next >= ivl) begin
            interval_next = '0;
            wait_next     = '0;
            ph            = PH_WAIT;
        end
        phase_next = ph;

        unique case (ph)
            PH_IDLE: begin
                phase_next = PH_IDLE;
            end
            PH_WAIT: begin
                if (!data_pin) begin
                    bit_cnt_next = '0;
                    shift_next   = '0;
                    phase_next   = PH_BIT_HIGH;
                end else begin
                    wait_next = wait_next + 1'b1;
                    if (wait_next >= tmo) begin
                        res.timed_out = 1'b1;
                        finish        = 1'b1;
                    end
                end
            end
            PH_BIT_HIGH: begin
                res.clock_pin = 1'b1;
                phase_next    = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
                shift_next   = {shift_reg[SAMPLE_BITS-2:0], data_pin};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                phase_next   = (bit_cnt_next >= BIT_CNT_W'(SAMPLE_BITS)) ?
                               PH_GAIN_HIGH : PH_BIT_HIGH;
            end
            PH_GAIN_HIGH: begin
                res.clock_pin = 1'b1;
                phase_next    = PH_GAIN_LOW;
            end
            PH_GAIN_LOW: begin
                raw    = shift_reg;
                finish = 1'b1;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        if (finish) begin
            res.read_done = 1'b1;
            res.raw       = RAW_W'(raw);
            phase_next    = PH_IDLE;
            if (tare_p) begin
                offset_next   = raw;
                tare_next     = 1'b0;
                res.tare_done = 1'b1;
            end else if (raw != '0) begin
                res.div_req = 1'b1;
            end
        end

        diff    = DIFF_W'(raw) - DIFF_W'(offset_reg);
        num_neg = diff[DIFF_W-1];
        mag     = num_neg ? -diff : diff;
        num_mag = MAG_W'(mag[SAMPLE_BITS-1:0]) << FRACTION_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            bit_cnt_reg  <= '0;
            shift_reg    <= '0;
            interval_reg <= '0;
            wait_reg     <= '0;
            offset_reg   <= '0;
            tare_reg     <= 1'b0;
        end else if (step) begin
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            interval_reg <= interval_next;
            wait_reg     <= wait_next;
            offset_reg   <= offset_next;
            tare_reg     <= tare_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/load_cell_adc_reader.sv -----
// Timing: a tick's result is registered as its request is taken; a tick
//   that ends a read and updates the weight waits for the shared restoring
//   divider, which retires one quotient bit per cycle over 32 bits.
// Throughput: 1 tick per cycle; s_tready is low while dividing or stalled.
// Reset: synchronous on aresetn low; clears phase, counters, tare offset, weight
//   and restores the default configuration.
`default_nettype none

module load_cell_adc_reader (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lcar_pkg::S_TDATA_W-1:0]   s_tdata,   // data_pin
    input  logic [lcar_pkg::S_TUSER_W-1:0]   s_tuser,   // op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // clock_pin, read_done, timed_out, raw_reading[24], tare_done, weight[33]
    output logic [lcar_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lcar_pkg::*;

    logic [FACTOR_W-1:0]   factor_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;

    ctl_t                  ctl_reg, ctl_next;
    logic                  m_valid_reg, m_valid_next;
    result_t               result_reg, result_next;
    logic [WEIGHT_W-1:0]   weight_reg, weight_next;

    logic                  accept;
    logic                  div_start;
    logic                  div_done;
    logic [WEIGHT_W-1:0]   quotient;
    logic [FACTOR_W-1:0]   divisor;
    tick_res_t             tick_res;
    logic [MAG_W-1:0]      num_mag;
    logic                  num_neg;

    assign s_tready = (ctl_reg == CTL_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign divisor  = (factor_reg == '0) ? FACTOR_W'(1) : factor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg   <= FACTOR_RESET;
            interval_reg <= INTERVAL_RESET;
            timeout_reg  <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FACTOR:   factor_reg   <= cfg_data[FACTOR_W-1:0];
                CFG_INTERVAL: interval_reg <= cfg_data[INTERVAL_W-1:0];
                CFG_TIMEOUT:  timeout_reg  <= cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    lcar_tick u_tick (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (accept),
        .op       (s_tuser[0]),
        .data_pin (s_tdata[0]),
        .interval (interval_reg),
        .timeout  (timeout_reg),
        .res      (tick_res),
        .num_mag  (num_mag),
        .num_neg  (num_neg)
    );

    lcar_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num_mag  (num_mag),
        .num_neg  (num_neg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        ctl_next     = ctl_reg;
        m_valid_next = m_valid_reg;
        result_next  = result_reg;
        weight_next  = weight_reg;
        div_start    = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (ctl_reg)
            CTL_IDLE: begin
                if (accept) begin
                    result_next.pad       = '0;
                    result_next.clock_pin = tick_res.clock_pin;
                    result_next.read_done = tick_res.read_done;
                    result_next.timed_out = tick_res.timed_out;
                    result_next.raw       = tick_res.raw;
                    result_next.tare_done = tick_res.tare_done;
                    result_next.weight    = weight_reg;
                    if (tick_res.div_req) begin
                        div_start = 1'b1;
                        ctl_next  = CTL_DIV;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            CTL_DIV: begin
                if (div_done) begin
                    weight_next        = quotient;
                    result_next.weight = quotient;
                    m_valid_next       = 1'b1;
                    ctl_next           = CTL_IDLE;
                end
            end
            default: begin
                ctl_next = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg     <= CTL_IDLE;
            m_valid_reg <= 1'b0;
            weight_reg  <= '0;
        end else begin
            ctl_reg     <= ctl_next;
            m_valid_reg <= m_valid_next;
            weight_reg  <= weight_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg;

endmodule

`default_nettype wire

// ----- design/lcar_checker.sv -----
`default_nettype none

`include "load_cell_adc_reader_assert.svh"

module lcar_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [lcar_pkg::M_TDATA_W-1:0] m_tdata
);
    import lcar_pkg::*;

    result_t res;

    assign res = m_tdata;

    `LCAR_IMPLY(a_timeout_ends_read, m_tvalid && res.timed_out, res.read_done, "timeout without read end")
    `LCAR_IMPLY(a_timeout_raw_zero, m_tvalid && res.timed_out, res.raw == '0, "timeout with nonzero raw")
    `LCAR_IMPLY(a_tare_ends_read, m_tvalid && res.tare_done, res.read_done, "tare without read end")
    `LCAR_IMPLY(a_clock_low_at_end, m_tvalid && res.read_done, !res.clock_pin, "clock high at read end")
    `LCAR_IMPLY(a_result_holds, m_tvalid && !m_tready, ##1 m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind load_cell_adc_reader lcar_checker u_lcar_checker (.*);

`default_nettype wire
